FILE: design/tpca_pkg.sv
`timescale 1ns / 1ps

package tpca_pkg;

    localparam int PERIOD_W  = 16;
    localparam int SAMPLE_W  = 21;
    localparam int PEAK_W    = 17;
    localparam int STEP_W    = 14;
    localparam int DIV_W     = 18;
    localparam int DVSR_W    = 17;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int PROD_W    = 31;
    localparam int UFAC_W    = 15;

    // floor(x / 1000) as floor(((x >> 3) * MS_RECIP) >> MS_RECIP_SHIFT)
    localparam int MS_RECIP_W     = 29;
    localparam int MS_RECIP_SHIFT = 35;
    localparam int MS_PROD_W      = PROD_W - 3 + MS_RECIP_W;

    localparam logic [PERIOD_W-1:0] MIN_START = 16'd65535;
    localparam logic [PERIOD_W-1:0] MAX_START = 16'd1;
    localparam logic [SAMPLE_W-1:0] MIN_SAMPLE_MS = 21'd500;
    localparam logic [SAMPLE_W-1:0] TRIGGER_SAMPLE_MS = 21'd750;
    localparam logic [UFAC_W-1:0] FACTOR_TENTH_MS = 15'd18600;
    localparam logic [UFAC_W-1:0] FACTOR_US = 15'd186;
    localparam logic [MS_RECIP_W-1:0] MS_RECIP = 29'd274877907;

    localparam logic MODE_TOOTH   = 1'b0;
    localparam logic MODE_TRIGGER = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_RATIO,
        ST_SAMPLE,
        ST_OUT
    } tpca_state_t;

    typedef struct packed {
        logic accept_en;
        logic prod_load;
        logic div_start;
        logic ratio_load;
        logic sample_load;
        logic out_load;
    } tpca_cmd_t;

    typedef struct packed {
        logic last_accept;
        logic mode;
        logic div_busy;
        logic div_done;
        logic out_free;
    } tpca_sts_t;

    function automatic logic [STEP_W-1:0] axis_step_f(input logic [PEAK_W-1:0] peak);
        logic [STEP_W-1:0] step;
        if (peak < 17'd750)        step = 14'd100;
        else if (peak < 17'd1500)  step = 14'd250;
        else if (peak < 17'd3000)  step = 14'd500;
        else if (peak < 17'd6000)  step = 14'd1000;
        else if (peak < 17'd12000) step = 14'd1500;
        else if (peak < 17'd24000) step = 14'd3000;
        else if (peak < 17'd48000) step = 14'd6000;
        else                       step = 14'd12000;
        return step;
    endfunction

endpackage

FILE: design/tpca_div.sv
`timescale 1ns / 1ps

module tpca_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [tpca_pkg::DIV_W-1:0]     dividend,
    input  logic [tpca_pkg::DVSR_W-1:0]    divisor,
    output logic                           busy,
    output logic                           done,
    output logic [tpca_pkg::DIV_W-1:0]     quotient
);
    import tpca_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     dvd_reg, dvd_next;
    logic [DVSR_W-1:0]    rem_reg, rem_next;
    logic [DVSR_W-1:0]    dvsr_reg, dvsr_next;
    logic [DVSR_W:0]      trial;

    assign trial = {rem_reg, dvd_reg[DIV_W-1]} - {1'b0, dvsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        if (start && !busy_reg) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_W - 1);
            dvd_next  = dividend;
            rem_next  = '0;
            dvsr_next = divisor;
        end else if (busy_reg) begin
            if (!trial[DVSR_W]) begin
                rem_next = trial[DVSR_W-1:0];
                dvd_next = {dvd_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[DVSR_W-2:0], dvd_reg[DIV_W-1]};
                dvd_next = {dvd_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = dvd_reg;

    // remainder stays below the divisor between steps
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && $past(busy_reg) |-> rem_reg < dvsr_reg)
        else $error("divider remainder out of range");

endmodule

FILE: design/tpca_ctrl.sv
`timescale 1ns / 1ps

module tpca_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tpca_pkg::tpca_sts_t  sts,
    output tpca_pkg::tpca_cmd_t  cmd
);
    import tpca_pkg::*;

    tpca_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (sts.last_accept) begin
                    state_next = (sts.mode == MODE_TOOTH) ? ST_MUL : ST_OUT;
                end
            end
            ST_MUL: begin
                state_next = ST_SAMPLE;
            end
            ST_SAMPLE: begin
                state_next = ST_RATIO;
            end
            ST_RATIO: begin
                if (sts.div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                cmd.accept_en = 1'b1;
            end
            ST_MUL: begin
                cmd.prod_load = 1'b1;
                cmd.div_start = 1'b1;
            end
            ST_SAMPLE: begin
                cmd.sample_load = 1'b1;
            end
            ST_RATIO: begin
                if (sts.div_done) begin
                    cmd.ratio_load = 1'b1;
                end
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                end
            end
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("summary loaded over a pending transaction");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> !sts.div_busy)
        else $error("divider started while busy");

endmodule

FILE: design/tpca_dp.sv
`timescale 1ns / 1ps

module tpca_dp (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  tpca_pkg::tpca_cmd_t              cmd,
    output tpca_pkg::tpca_sts_t              sts,
    input  logic                             cfg_wr_en,
    input  logic                             cfg_wr_data,
    input  logic                             s_valid,
    input  logic [tpca_pkg::PERIOD_W-1:0]    s_tooth_period,
    input  logic                             s_tenth_ms_units,
    input  logic                             s_last_sample,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [tpca_pkg::PERIOD_W-1:0]    m_min_period,
    output logic [tpca_pkg::PERIOD_W-1:0]    m_max_period,
    output logic [tpca_pkg::PERIOD_W-1:0]    m_missing_teeth,
    output logic [tpca_pkg::SAMPLE_W-1:0]    m_sample_time_ms,
    output logic [tpca_pkg::PEAK_W-1:0]      m_display_peak,
    output logic [tpca_pkg::STEP_W-1:0]      m_axis_step
);
    import tpca_pkg::*;

    logic                accept;
    logic                mode_reg;
    logic [PERIOD_W-1:0] min_reg, min_next;
    logic [PERIOD_W-1:0] max_reg, max_next;
    logic [PERIOD_W-1:0] held_reg, held_next;
    logic                units_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [PERIOD_W-1:0] ratio_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic                m_valid_reg, m_valid_next;
    logic [PERIOD_W-1:0] out_min_reg, out_max_reg, out_miss_reg;
    logic [SAMPLE_W-1:0] out_sample_reg;
    logic [PEAK_W-1:0]   out_peak_reg;
    logic [STEP_W-1:0]   out_step_reg;

    logic [UFAC_W-1:0]    ufac;
    logic [DIV_W-1:0]     div_dividend;
    logic [DVSR_W-1:0]    div_divisor;
    logic                 div_busy, div_done;
    logic [DIV_W-1:0]     div_q;
    logic [PROD_W-4:0]    prod_div8;
    logic [MS_PROD_W-1:0] ms_prod;
    logic [PEAK_W+1:0]    peak_x4;
    logic [PEAK_W-1:0]    peak;
    logic [SAMPLE_W-1:0]  sample_val;

    assign accept = s_valid && cmd.accept_en;

    always_comb begin
        min_next = min_reg;
        max_next = max_reg;
        if (accept) begin
            if (s_tooth_period != '0 && s_tooth_period < min_reg) begin
                min_next = s_tooth_period;
            end
            if (s_tooth_period > max_reg) begin
                max_next = s_tooth_period;
            end
        end
        if (cmd.out_load) begin
            min_next = MIN_START;
            max_next = MAX_START;
        end
    end

    assign ufac = units_reg ? FACTOR_TENTH_MS : FACTOR_US;

    assign div_dividend = DIV_W'({1'b0, max_reg, 1'b0} + {2'b00, min_reg});
    assign div_divisor  = {min_reg, 1'b0};

    tpca_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    assign prod_div8 = prod_reg[PROD_W-1:3];
    assign ms_prod   = {{MS_RECIP_W{1'b0}}, prod_div8} * {{(PROD_W-3){1'b0}}, MS_RECIP};

    assign peak_x4 = {3'b000, max_reg} + {1'b0, max_reg, 2'b00};
    assign peak    = peak_x4[PEAK_W+1:2];

    always_comb begin
        if (mode_reg == MODE_TRIGGER) begin
            sample_val = TRIGGER_SAMPLE_MS;
        end else if (sample_reg < MIN_SAMPLE_MS) begin
            sample_val = MIN_SAMPLE_MS;
        end else begin
            sample_val = sample_reg;
        end
    end

    always_comb begin
        held_next = held_reg;
        if (cmd.out_load && mode_reg == MODE_TOOTH) begin
            held_next = (ratio_reg == '0) ? '0 : ratio_reg - 1'b1;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_TOOTH;
            min_reg     <= MIN_START;
            max_reg     <= MAX_START;
            held_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                mode_reg <= cfg_wr_data;
            end
            min_reg     <= min_next;
            max_reg     <= max_next;
            held_reg    <= held_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_last_sample) begin
            units_reg <= s_tenth_ms_units;
        end
        if (cmd.prod_load) begin
            prod_reg <= PROD_W'(min_reg) * PROD_W'(ufac);
        end
        if (cmd.ratio_load) begin
            ratio_reg <= div_q[PERIOD_W-1:0];
        end
        if (cmd.sample_load) begin
            sample_reg <= ms_prod[MS_RECIP_SHIFT+SAMPLE_W-1:MS_RECIP_SHIFT];
        end
        if (cmd.out_load) begin
            out_min_reg    <= min_reg;
            out_max_reg    <= max_reg;
            out_miss_reg   <= held_next;
            out_sample_reg <= sample_val;
            out_peak_reg   <= peak;
            out_step_reg   <= axis_step_f(peak);
        end
    end

    assign sts.last_accept = accept && s_last_sample;
    assign sts.mode        = mode_reg;
    assign sts.div_busy    = div_busy;
    assign sts.div_done    = div_done;
    assign sts.out_free    = !m_valid_reg || m_ready;

    assign m_valid          = m_valid_reg;
    assign m_min_period     = out_min_reg;
    assign m_max_period     = out_max_reg;
    assign m_missing_teeth  = out_miss_reg;
    assign m_sample_time_ms = out_sample_reg;
    assign m_display_peak   = out_peak_reg;
    assign m_axis_step      = out_step_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid_reg && min_reg == MIN_START && max_reg == MAX_START)
        else $error("capture not restarted after summary");

    assert property (@(posedge aclk) disable iff (!aresetn)
        min_reg != '0 && max_reg != '0)
        else $error("running extreme reached zero");

endmodule

FILE: design/tooth_period_capture_analyzer_top.sv
`timescale 1ns / 1ps

// Tooth period capture analyzer. Each transaction on the s_ channel carries one tooth
// period; a period that is not marked last is folded into the running minimum and
// maximum, and the next one can follow directly. The transaction marked last ends
// the capture: in tooth mode a one-bit-per-cycle divider runs 18 steps for the
// missing-tooth ratio (the sample time is formed meanwhile by a multiply by the
// reciprocal of 1000); in trigger mode no division is done. Either way the summary is
// loaded once the output register is free, and the block then returns to idle for the
// next period. No new period is taken while a summary is being formed. The summary is
// held in an output register, so it may wait on m_ready while the next capture starts
// streaming in; a further summary then waits until that register is free.
// logger_mode is written through cfg_wr_en/cfg_wr_data; the user writes it only while
// the block is idle, which the block itself does not enforce.

module tooth_period_capture_analyzer_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic                             cfg_wr_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [tpca_pkg::PERIOD_W-1:0]    s_tooth_period,
    input  logic                             s_tenth_ms_units,
    input  logic                             s_last_sample,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [tpca_pkg::PERIOD_W-1:0]    m_min_period,
    output logic [tpca_pkg::PERIOD_W-1:0]    m_max_period,
    output logic [tpca_pkg::PERIOD_W-1:0]    m_missing_teeth,
    output logic [tpca_pkg::SAMPLE_W-1:0]    m_sample_time_ms,
    output logic [tpca_pkg::PEAK_W-1:0]      m_display_peak,
    output logic [tpca_pkg::STEP_W-1:0]      m_axis_step
);
    import tpca_pkg::*;

    tpca_cmd_t cmd;
    tpca_sts_t sts;

    tpca_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .sts     (sts),
        .cmd     (cmd)
    );

    tpca_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_tooth_period   (s_tooth_period),
        .s_tenth_ms_units (s_tenth_ms_units),
        .s_last_sample    (s_last_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_min_period     (m_min_period),
        .m_max_period     (m_max_period),
        .m_missing_teeth  (m_missing_teeth),
        .m_sample_time_ms (m_sample_time_ms),
        .m_display_peak   (m_display_peak),
        .m_axis_step      (m_axis_step)
    );

    assign s_ready = cmd.accept_en;

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import tpca_pkg::*;

    localparam int     PERIOD_NS    = 10;
    localparam int     RESET_CYCLES = 11;
    localparam int     ITEMS        = 1100;
    localparam int     SETTLE       = 80;
    localparam int     LONG_HOLD    = 400;
    localparam longint LIMIT_CYCLES = 1000000;
    localparam int     DIR_ROWS     = 24;

    typedef struct packed {
        logic [PERIOD_W-1:0] min_period;
        logic [PERIOD_W-1:0] max_period;
        logic [PERIOD_W-1:0] missing_teeth;
        logic [SAMPLE_W-1:0] sample_time_ms;
        logic [PEAK_W-1:0]   display_peak;
        logic [STEP_W-1:0]   axis_step;
    } summary_t;

    typedef struct packed {
        logic                mode;
        logic [PERIOD_W-1:0] period;
        logic                tenth;
        logic                last;
        logic                typed;
        summary_t            want;
    } dir_row_t;

    localparam summary_t NO_SUM = '0;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic                cfg_wr_data = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [PERIOD_W-1:0] s_tooth_period = '0;
    logic                s_tenth_ms_units = 1'b0;
    logic                s_last_sample = 1'b0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [PERIOD_W-1:0] m_min_period;
    logic [PERIOD_W-1:0] m_max_period;
    logic [PERIOD_W-1:0] m_missing_teeth;
    logic [SAMPLE_W-1:0] m_sample_time_ms;
    logic [PEAK_W-1:0]   m_display_peak;
    logic [STEP_W-1:0]   m_axis_step;

    // predictor state
    logic [PERIOD_W-1:0] tooth_min = MIN_START;
    logic [PERIOD_W-1:0] tooth_max = MAX_START;
    logic [PERIOD_W-1:0] held_missing_q = '0;
    logic                mode_q = MODE_TOOTH;

    summary_t summary_q[$];
    dir_row_t dir_rows [DIR_ROWS];

    int  periods_sent = 0;
    int  summaries_checked = 0;
    int  mismatch_cnt = 0;
    int  stray_cnt = 0;
    int  mode_writes = 0;
    int  long_holds = 0;
    bit  quiet_src = 1'b0;
    bit  quiet_sink = 1'b0;
    bit  hold_req = 1'b0;

    tooth_period_capture_analyzer_top DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_tooth_period   (s_tooth_period),
        .s_tenth_ms_units (s_tenth_ms_units),
        .s_last_sample    (s_last_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_min_period     (m_min_period),
        .m_max_period     (m_max_period),
        .m_missing_teeth  (m_missing_teeth),
        .m_sample_time_ms (m_sample_time_ms),
        .m_display_peak   (m_display_peak),
        .m_axis_step      (m_axis_step)
    );

    initial begin
        forever begin
            #(PERIOD_NS / 2) aclk = ~aclk;
        end
    end

    initial begin
        #(LIMIT_CYCLES * PERIOD_NS);
        $display("[tooth_period_capture_analyzer_top] ERROR");
        $finish;
    end

    function automatic logic [STEP_W-1:0] grid_step(input longint peak);
        longint bound [7] = '{750, 1500, 3000, 6000, 12000, 24000, 48000};
        int     step [8] = '{100, 250, 500, 1000, 1500, 3000, 6000, 12000};
        int     idx;
        idx = 0;
        while (idx < 7 && peak >= bound[idx]) idx++;
        return step[idx][STEP_W-1:0];
    endfunction

    task automatic fold_period(input logic [PERIOD_W-1:0] p, input logic tenth,
                               input logic last, output bit done, output summary_t s);
        longint mn, mx, ratio, smp, pk;
        if (p != 0 && p < tooth_min) tooth_min = p;
        if (p > tooth_max) tooth_max = p;
        done = last;
        s = NO_SUM;
        if (last) begin
            mn = tooth_min;
            mx = tooth_max;
            pk = (mx * 5) / 4;
            if (mode_q == MODE_TOOTH) begin
                ratio = (2 * mx + mn) / (2 * mn);
                held_missing_q = (ratio == 0) ? '0 : PERIOD_W'(ratio - 1);
                smp = (186 * mn * (tenth ? 100 : 1)) / 1000;
                if (smp < MIN_SAMPLE_MS) smp = MIN_SAMPLE_MS;
            end else begin
                smp = TRIGGER_SAMPLE_MS;
            end
            s.min_period     = PERIOD_W'(mn);
            s.max_period     = PERIOD_W'(mx);
            s.missing_teeth  = held_missing_q;
            s.sample_time_ms = SAMPLE_W'(smp);
            s.display_peak   = PEAK_W'(pk);
            s.axis_step      = grid_step(pk);
            tooth_min = MIN_START;
            tooth_max = MAX_START;
        end
    endtask

    task automatic offer_period(input logic [PERIOD_W-1:0] p, input logic tenth,
                                input logic last, input logic typed, input summary_t want);
        int       gap;
        int       r;
        bit       done;
        summary_t calc;
        r = $urandom_range(0, 99);
        if (quiet_src || r < 60) gap = 0;
        else if (r < 90) gap = $urandom_range(1, 3);
        else if (r < 98) gap = $urandom_range(4, 10);
        else gap = $urandom_range(20, 60);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_tooth_period   <= p;
        s_tenth_ms_units <= tenth;
        s_last_sample    <= last;
        do @(posedge aclk); while (!s_ready);
        periods_sent++;
        fold_period(p, tenth, last, done, calc);
        if (done) summary_q.push_back(typed ? want : calc);
    endtask

    // only while idle: all summaries drained, then let the divider settle
    task automatic set_mode(input logic mode);
        s_valid <= 1'b0;
        while (summary_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        mode_q = mode;
        mode_writes++;
    endtask

    // output side: random stalls, quiet stretches, and a long hold on request
    initial begin
        int stall_cnt;
        int r;
        stall_cnt = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                stall_cnt = LONG_HOLD;
                long_holds++;
            end
            if (stall_cnt > 0) begin
                stall_cnt--;
                m_ready <= 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (quiet_sink || r < 70) begin
                    m_ready <= 1'b1;
                end else begin
                    m_ready <= 1'b0;
                    stall_cnt = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 80);
                end
            end
        end
    end

    always @(posedge aclk) begin
        summary_t got;
        summary_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_min_period, m_max_period, m_missing_teeth, m_sample_time_ms,
                    m_display_peak, m_axis_step};
            if (summary_q.size() == 0) begin
                stray_cnt++;
                if (mismatch_cnt + stray_cnt <= 10)
                    $display("unexpected summary transaction: %p", got);
            end else begin
                want = summary_q.pop_front();
                summaries_checked++;
                if (got.min_period !== want.min_period
                        || got.max_period !== want.max_period
                        || got.missing_teeth !== want.missing_teeth
                        || got.sample_time_ms !== want.sample_time_ms
                        || got.display_peak !== want.display_peak
                        || got.axis_step !== want.axis_step) begin
                    mismatch_cnt++;
                    if (mismatch_cnt + stray_cnt <= 10) begin
                        $display("summary %0d mismatch at %0t", summaries_checked, $time);
                        $display("  min  exp %0d got %0d  max  exp %0d got %0d",
                                 want.min_period, got.min_period,
                                 want.max_period, got.max_period);
                        $display("  miss exp %0d got %0d  smp  exp %0d got %0d",
                                 want.missing_teeth, got.missing_teeth,
                                 want.sample_time_ms, got.sample_time_ms);
                        $display("  peak exp %0d got %0d  step exp %0d got %0d",
                                 want.display_peak, got.display_peak,
                                 want.axis_step, got.axis_step);
                    end
                end
            end
        end
    end

    initial begin
        int          phase;
        int          n_caps;
        int          len;
        int          kind;
        int          base;
        int          mult;
        int          gap_at;
        int          p;
        logic [15:0] period;

        dir_rows = '{
            // all zero, then the two extremes
            '{MODE_TOOTH, 16'd0, 1'b0, 1'b1, 1'b1,
              '{16'd65535, 16'd1, 16'd0, 21'd12189, 17'd1, 14'd100}},
            '{MODE_TOOTH, 16'd65535, 1'b1, 1'b1, 1'b1,
              '{16'd65535, 16'd65535, 16'd0, 21'd1218951, 17'd81918, 14'd12000}},
            '{MODE_TOOTH, 16'd1, 1'b0, 1'b1, 1'b1,
              '{16'd1, 16'd1, 16'd0, 21'd500, 17'd1, 14'd100}},
            '{MODE_TOOTH, 16'd1, 1'b1, 1'b0, 1'b0, NO_SUM},
            '{MODE_TOOTH, 16'd65535, 1'b1, 1'b1, 1'b1,
              '{16'd1, 16'd65535, 16'd65534, 21'd500, 17'd81918, 14'd12000}},
            // wheel with a gap, units taken from the last transaction only
            '{MODE_TOOTH, 16'd1000, 1'b1, 1'b0, 1'b0, NO_SUM},
            '{MODE_TOOTH, 16'd1000, 1'b1, 1'b0, 1'b0, NO_SUM},
            '{MODE_TOOTH, 16'd3000, 1'b1, 1'b0, 1'b0, NO_SUM},
            '{MODE_TOOTH, 16'd1000, 1'b0, 1'b1, 1'b0, NO_SUM},
            // ratio exactly half way
            '{MODE_TOOTH, 16'd2, 1'b0, 1'b0, 1'b0, NO_SUM},
            '{MODE_TOOTH, 16'd3, 1'b0, 1'b1, 1'b0, NO_SUM},
            // zeros around one real period, last one zero
            '{MODE_TOOTH, 16'd0, 1'b1, 1'b0, 1'b0, NO_SUM},
            '{MODE_TOOTH, 16'd40000, 1'b1, 1'b0, 1'b0, NO_SUM},
            '{MODE_TOOTH, 16'd0, 1'b1, 1'b1, 1'b0, NO_SUM},
            // grid step boundaries
            '{MODE_TOOTH, 16'd599, 1'b0, 1'b1, 1'b0, NO_SUM},
            '{MODE_TOOTH, 16'd600, 1'b0, 1'b1, 1'b0, NO_SUM},
            '{MODE_TOOTH, 16'd38399, 1'b0, 1'b1, 1'b0, NO_SUM},
            '{MODE_TOOTH, 16'd38400, 1'b0, 1'b1, 1'b0, NO_SUM},
            '{MODE_TOOTH, 16'd2689, 1'b1, 1'b1, 1'b0, NO_SUM},
            '{MODE_TOOTH, 16'd2, 1'b0, 1'b0, 1'b0, NO_SUM},
            '{MODE_TOOTH, 16'd5, 1'b0, 1'b1, 1'b0, NO_SUM},
            // trigger mode keeps the held estimate
            '{MODE_TRIGGER, 16'd65535, 1'b1, 1'b1, 1'b1,
              '{16'd65535, 16'd65535, 16'd2, 21'd750, 17'd81918, 14'd12000}},
            '{MODE_TRIGGER, 16'd0, 1'b0, 1'b1, 1'b1,
              '{16'd65535, 16'd1, 16'd2, 21'd750, 17'd1, 14'd100}},
            '{MODE_TRIGGER, 16'd700, 1'b1, 1'b1, 1'b0, NO_SUM}
        };

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        set_mode(MODE_TOOTH);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].mode != mode_q) set_mode(dir_rows[i].mode);
            offer_period(dir_rows[i].period, dir_rows[i].tenth, dir_rows[i].last,
                         dir_rows[i].typed, dir_rows[i].want);
        end

        phase = 0;
        while (periods_sent < ITEMS + DIR_ROWS) begin
            set_mode(phase[0] ? MODE_TRIGGER : MODE_TOOTH);
            quiet_src  = ($urandom_range(0, 3) == 0);
            quiet_sink = ($urandom_range(0, 3) == 0);
            if (phase == 2 || phase == 7) begin
                quiet_src  = 1'b1;
                quiet_sink = 1'b0;
                hold_req   = 1'b1;
            end
            n_caps = $urandom_range(2, 8);
            repeat (n_caps) begin
                kind   = $urandom_range(0, 9);
                len    = ($urandom_range(0, 11) == 0) ? 93 : $urandom_range(1, 24);
                base   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535)
                                                     : $urandom_range(1, 16000);
                mult   = $urandom_range(1, 4);
                gap_at = $urandom_range(0, len - 1);
                for (int i = 0; i < len; i++) begin
                    if (kind < 6) begin
                        p = base + $urandom_range(0, base / 16) - base / 32;
                        if (i == gap_at) p = base * mult;
                        if (p < 1) p = 1;
                        if (p > 65535) p = 65535;
                    end else if (kind < 8) begin
                        p = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 65535);
                    end else if (kind == 8) begin
                        p = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535) : 0;
                    end else begin
                        p = $urandom_range(0, 7);
                    end
                    period = p[15:0];
                    offer_period(period, 1'($urandom_range(0, 1)), i == len - 1,
                                 1'b0, NO_SUM);
                end
            end
            phase++;
        end

        s_valid <= 1'b0;
        quiet_sink = 1'b0;
        while (summary_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);

        $display("sent %0d tooth periods in %0d phases, checked %0d capture summaries",
                 periods_sent, phase, summaries_checked);
        $display("logger mode written %0d times, %0d long output holds, %0d mismatches",
                 mode_writes, long_holds, mismatch_cnt + stray_cnt);
        if (mismatch_cnt == 0 && stray_cnt == 0 && summary_q.size() == 0) begin
            $display("[tooth_period_capture_analyzer_top] OK");
        end else begin
            $display("[tooth_period_capture_analyzer_top] ERROR");
        end
        $finish;
    end

endmodule
